### rtl/pifc_pkg.sv
package pifc_pkg;

  localparam int TableDepthDefault = 16;
  localparam int DeadbandQ12 = 20;
  localparam int DisableHoldMs = 500;
  localparam int CfgIndexWidth = 3;
  localparam int CfgDataWidth = 16;

  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_START   = 2'd2;
  localparam logic [1:0] FUNC_LOAD    = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TOO_HIGH = 2'd1;
  localparam logic [1:0] STATUS_TOO_LOW  = 2'd2;
  localparam logic [1:0] STATUS_NOT_RUN  = 2'd3;

  localparam logic [2:0] REG_MIN_ANGLE   = 3'd0;
  localparam logic [2:0] REG_MAX_ANGLE   = 3'd1;
  localparam logic [2:0] REG_KI          = 3'd2;
  localparam logic [2:0] REG_IZONE       = 3'd3;
  localparam logic [2:0] REG_SLOT_EN     = 3'd4;
  localparam logic [2:0] REG_WIN_LOW     = 3'd5;
  localparam logic [2:0] REG_WIN_HIGH    = 3'd6;
  localparam logic [2:0] REG_TABLE_COUNT = 3'd7;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] position;
    logic               disabled;
    logic [31:0]        time_ms;
    logic signed [15:0] request_angle;
    logic [3:0]         point_index;
    logic signed [15:0] point_angle;
    logic signed [15:0] point_volts;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] setpoint;
    logic signed [23:0] feedforward;
    logic               gain_slot;
    logic [1:0]         status;
  } out_item_t;

  // Table point: angle key in the upper half, value in the lower half.
  typedef struct packed {
    logic signed [15:0] angle;
    logic signed [15:0] volts;
  } point_t;

endpackage

### rtl/pifc_if.sv
interface pifc_in_if;
  logic valid;
  logic ready;
  pifc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pifc_out_if;
  logic valid;
  logic ready;
  pifc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/pifc_ram.sv
module pifc_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### rtl/pifc_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module pifc_div #(
  parameter int NumWidth = 48,
  parameter int DenWidth = 17
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NumWidth-1:0] num,
  input  logic [DenWidth-1:0] den,
  output logic                done,
  output logic [NumWidth-1:0] quot
);
  localparam int CntWidth = $clog2(NumWidth + 1);

  logic [DenWidth:0]   rem;
  logic [DenWidth-1:0] dvs;
  logic [CntWidth-1:0] cnt;
  logic                busy;
  logic [DenWidth:0]   shifted;

  assign shifted = {rem[DenWidth-1:0], quot[NumWidth-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntWidth'(NumWidth);
        rem  <= '0;
        dvs  <= den;
        quot <= num;
      end else if (busy) begin
        if (shifted >= {1'b0, dvs}) begin
          rem  <= shifted - {1'b0, dvs};
          quot <= {quot[NumWidth-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[NumWidth-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### rtl/pivot_integral_feedforward_controller.sv
// Pivot angle supervisor with integral term and table feedforward.
// Input channel "in" carries one item (tick, setpoint request, start or table
// point load); every item gives exactly one result on channel "out".
// Configuration is a write port (cfg_we, cfg_index, cfg_data); the user is to
// write it only while idle, as the block itself does not enforce this. Table
// points sit in one synchronous RAM, one point a word. A tick scans the RAM one
// point a cycle until the first key above the position or the last point, then
// divides for the interpolation with a 48-step bit-serial divider when needed.
// Request, start and load items go through execute and done; a tick passes
// execute, the scan on a non-empty table, multiply and divide when it
// interpolates, then the integral gain step before done.
// One item is in work at a time and the next is taken once the result is
// loaded into the output register. A finished item waits while the output
// register still holds an earlier result, and the input is held off until it
// moves on. Reset (synchronous, rst high) clears the setpoint, integral,
// running flag and stamp, empties the output register and restores the
// register defaults. Table contents stay undefined until loaded. When the
// receiver stalls, the result holds in the output register.
module pivot_integral_feedforward_controller #(
  parameter int TableDepth = pifc_pkg::TableDepthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  pifc_in_if.sink                             in,
  pifc_out_if.source                          out,
  input  logic                                cfg_we,
  input  logic [pifc_pkg::CfgIndexWidth-1:0]  cfg_index,
  input  logic [pifc_pkg::CfgDataWidth-1:0]   cfg_data
);
  localparam int AddrWidth = $clog2(TableDepth);
  localparam int CntWidth  = $clog2(TableDepth + 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_EXEC  = 7'b0000010,
    ST_SCAN  = 7'b0000100,
    ST_MUL   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_KI    = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t state;

  logic [14:0]        angle_floor, angle_ceiling, integral_gain, integral_zone;
  logic               slot_switch_enable;
  logic signed [15:0] slot_window_low, slot_window_high;
  logic [4:0]         table_count;

  logic signed [15:0] setpoint_reg;
  logic signed [31:0] integral_sum;
  logic               running_flag;
  logic [31:0]        disable_stamp;
  logic               disable_stamp_held;

  pifc_pkg::in_item_t  item;
  pifc_pkg::out_item_t result;
  logic                out_full;
  logic [1:0]          res_status;
  logic                res_slot;
  logic [1:0]          req_status;
  logic                slot_hit;

  // Point RAM.
  logic                 ram_we;
  logic [AddrWidth-1:0] ram_waddr, ram_raddr;
  pifc_pkg::point_t     ram_wdata, ram_rdata;

  pifc_ram #(.Width($bits(pifc_pkg::point_t)), .Depth(TableDepth)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Scan bookkeeping.
  logic [CntWidth-1:0]  n_pts;
  logic [CntWidth-1:0]  scan_idx;   // index of the point whose data arrives now
  logic                 scan_wait;  // first cycle: read still in flight
  pifc_pkg::point_t     prev_pt;
  logic signed [15:0]   lo_angle, hi_angle;
  logic signed [15:0]   lo_val;
  logic signed [24:0]   table_val;
  logic signed [47:0]   product;
  logic                 prod_neg;
  logic signed [46:0]   ki_prod;

  // Divider.
  logic        div_start, div_done;
  logic [47:0] div_num, div_quot;
  logic [16:0] div_den;
  logic [16:0] span;

  pifc_div #(.NumWidth(48), .DenWidth(17)) u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_quot)
  );

  assign in.ready = (state == ST_IDLE);
  assign out.valid = out_full;
  assign out.data  = result;

  always_comb begin
    if (32'(table_count) > 32'(TableDepth)) begin
      n_pts = CntWidth'(TableDepth);
    end else begin
      n_pts = CntWidth'(table_count);
    end
  end

  always_comb begin
    ram_we    = in.valid && in.ready && (in.data.func == pifc_pkg::FUNC_LOAD) &&
                (32'(in.data.point_index) < 32'(TableDepth));
    ram_waddr = AddrWidth'(in.data.point_index);
    ram_wdata = '{angle: in.data.point_angle, volts: in.data.point_volts};
    if (state == ST_SCAN && !scan_wait) begin
      ram_raddr = AddrWidth'(scan_idx + 1'b1);
    end else begin
      ram_raddr = '0;
    end
  end

  always_comb begin
    if (item.request_angle > $signed({1'b0, angle_ceiling})) begin
      req_status = pifc_pkg::STATUS_TOO_HIGH;
    end else if (item.request_angle < $signed({1'b0, angle_floor})) begin
      req_status = pifc_pkg::STATUS_TOO_LOW;
    end else if (!running_flag) begin
      req_status = pifc_pkg::STATUS_NOT_RUN;
    end else begin
      req_status = pifc_pkg::STATUS_OK;
    end
  end

  assign slot_hit = slot_switch_enable && (item.position > slot_window_low) &&
                    (item.position < slot_window_high);

  // Tick arithmetic on the integral.
  logic signed [16:0] err;
  logic [16:0]        aerr;
  logic signed [32:0] isum_add;
  logic signed [31:0] isum_sat;

  always_comb begin
    err  = 17'(setpoint_reg) - 17'(item.position);
    aerr = err[16] ? 17'(-err) : 17'(err);
    isum_add = 33'(integral_sum) + 33'(err);
    if (isum_add > 33'sh0_7FFF_FFFF) begin
      isum_sat = 32'sh7FFF_FFFF;
    end else if (isum_add < -33'sh0_8000_0000) begin
      isum_sat = 32'sh8000_0000;
    end else begin
      isum_sat = isum_add[31:0];
    end
  end

  logic signed [33:0] ki_term;
  logic [46:0]        ki_mag;
  logic [32:0]        ki_q;
  logic signed [34:0] ff_sum;
  logic signed [23:0] ff_sat;

  always_comb begin
    ki_mag = ki_prod[46] ? 47'(-ki_prod) : 47'(ki_prod);
    ki_q   = 33'((ki_mag + 47'd8192) >> 14);
    ki_term = ki_prod[46] ? -$signed({1'b0, ki_q}) : $signed({1'b0, ki_q});
    ff_sum = 35'(table_val) + 35'(ki_term);
    if (ff_sum > 35'sd8388607) begin
      ff_sat = 24'sd8388607;
    end else if (ff_sum < -35'sd8388608) begin
      ff_sat = -24'sd8388608;
    end else begin
      ff_sat = ff_sum[23:0];
    end
  end

  always_comb begin
    span      = 17'(hi_angle) - 17'(lo_angle);
    div_start = (state == ST_MUL);
    div_num   = (product[47] ? 48'(-product) : 48'(product)) + 48'(span >> 1);
    div_den   = span;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      out_full           <= 1'b0;
      angle_floor        <= '0;
      angle_ceiling      <= 15'd25723;
      integral_gain      <= '0;
      integral_zone      <= '0;
      slot_switch_enable <= 1'b0;
      slot_window_low    <= '0;
      slot_window_high   <= '0;
      table_count        <= '0;
      setpoint_reg       <= '0;
      integral_sum       <= '0;
      running_flag       <= 1'b0;
      disable_stamp      <= '0;
      disable_stamp_held <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pifc_pkg::REG_MIN_ANGLE:   angle_floor        <= cfg_data[14:0];
          pifc_pkg::REG_MAX_ANGLE:   angle_ceiling      <= cfg_data[14:0];
          pifc_pkg::REG_KI:          integral_gain      <= cfg_data[14:0];
          pifc_pkg::REG_IZONE:       integral_zone      <= cfg_data[14:0];
          pifc_pkg::REG_SLOT_EN:     slot_switch_enable <= cfg_data[0];
          pifc_pkg::REG_WIN_LOW:     slot_window_low    <= cfg_data;
          pifc_pkg::REG_WIN_HIGH:    slot_window_high   <= cfg_data;
          pifc_pkg::REG_TABLE_COUNT: table_count        <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (state == ST_DONE && (!out_full || out.ready)) begin
        out_full <= 1'b1;
      end else if (out.valid && out.ready) begin
        out_full <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in.valid && in.ready) begin
            item  <= in.data;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_status <= (item.func == pifc_pkg::FUNC_REQUEST) ? req_status
                                                              : pifc_pkg::STATUS_OK;
          res_slot   <= (item.func == pifc_pkg::FUNC_TICK) && slot_hit;
          case (item.func)
            pifc_pkg::FUNC_TICK: begin
              if (item.disabled) begin
                if (!disable_stamp_held) begin
                  disable_stamp      <= item.time_ms;
                  disable_stamp_held <= 1'b1;
                end else if ((item.time_ms - disable_stamp) > 32'(pifc_pkg::DisableHoldMs)) begin
                  setpoint_reg <= item.position;
                end
                integral_sum <= '0;
              end else begin
                disable_stamp_held <= 1'b0;
                if (aerr <= 17'(pifc_pkg::DeadbandQ12) || aerr > 17'(integral_zone)) begin
                  integral_sum <= '0;
                end else begin
                  integral_sum <= isum_sat;
                end
              end
              scan_idx  <= '0;
              scan_wait <= 1'b1;
              table_val <= '0;
              if (n_pts == '0) begin
                state <= ST_KI;
              end else begin
                state <= ST_SCAN;
              end
            end
            pifc_pkg::FUNC_REQUEST: begin
              if (req_status == pifc_pkg::STATUS_OK) begin
                setpoint_reg <= item.request_angle;
              end
              state <= ST_DONE;
            end
            pifc_pkg::FUNC_START: begin
              running_flag <= 1'b1;
              setpoint_reg <= $signed({1'b0, angle_floor});
              integral_sum <= '0;
              state        <= ST_DONE;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_SCAN: begin
          if (scan_wait) begin
            scan_wait <= 1'b0;
          end else begin
            prev_pt  <= ram_rdata;
            scan_idx <= scan_idx + 1'b1;
            if (ram_rdata.angle > item.position) begin
              if (scan_idx == '0) begin
                table_val <= 25'(ram_rdata.volts);
                state     <= ST_KI;
              end else if (ram_rdata.angle <= prev_pt.angle) begin
                table_val <= 25'(prev_pt.volts);
                state     <= ST_KI;
              end else begin
                lo_angle <= prev_pt.angle;
                hi_angle <= ram_rdata.angle;
                lo_val   <= prev_pt.volts;
                product  <= 48'((17'(ram_rdata.volts) - 17'(prev_pt.volts)) *
                                (18'(item.position) - 18'(prev_pt.angle)));
                state    <= ST_MUL;
              end
            end else if (scan_idx + 1'b1 == n_pts) begin
              table_val <= 25'(ram_rdata.volts);
              state     <= ST_KI;
            end
          end
        end
        ST_MUL: begin
          prod_neg <= product[47];
          state    <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (prod_neg) begin
              table_val <= 25'(lo_val) - 25'(div_quot);
            end else begin
              table_val <= 25'(lo_val) + 25'(div_quot);
            end
            state <= ST_KI;
          end
        end
        ST_KI: begin
          ki_prod <= 47'($signed({1'b0, integral_gain}) * integral_sum);
          state   <= ST_DONE;
        end
        ST_DONE: begin
          // The finished item moves out once the output register is free.
          if (!out_full || out.ready) begin
            result.setpoint    <= setpoint_reg;
            result.feedforward <= (item.func == pifc_pkg::FUNC_TICK) ? ff_sat : '0;
            result.gain_slot   <= res_slot;
            result.status      <= res_status;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/pifc_checker.sv
module pifc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken");
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_status)) else $error("result changed while waiting");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");
endmodule

bind pivot_integral_feedforward_controller pifc_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in.valid), .in_ready(in.ready),
  .out_valid(out.valid), .out_ready(out.ready), .out_status(out.data.status)
);

### verif/pifc_checker.sv
module pifc_scoreboard (
  input  logic                               clk,
  input  logic                               rst,
  pifc_in_if                                 in_ch,
  pifc_out_if                                out_ch,
  input  logic                               cfg_we,
  input  logic [pifc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [pifc_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                 errors,
  output int                                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PointCount = pifc_pkg::TableDepthDefault;

  // Shadow of the configuration registers.
  int unsigned angle_floor, angle_ceiling, ki, izone, slot_en, tbl_count;
  int win_low, win_high;

  // Shadow of the controller state.
  int sp_q;
  int isum;
  bit running;
  logic [31:0] stamp;
  bit stamp_held;
  int pt_angle [PointCount];
  int pt_volts [PointCount];

  pifc_pkg::out_item_t expected_results[$];

  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint table_value(int pos);
    int n, i;
    longint alo, ahi, vlo, vhi;
    n = (tbl_count > PointCount) ? PointCount : int'(tbl_count);
    if (n == 0) return 0;
    for (i = 0; i < n; i++) begin
      if (pt_angle[i] > pos) break;
    end
    if (i == n) return pt_volts[n-1];
    if (i == 0) return pt_volts[0];
    alo = pt_angle[i-1];
    ahi = pt_angle[i];
    vlo = pt_volts[i-1];
    vhi = pt_volts[i];
    if (ahi <= alo) return vlo;
    return vlo + round_div((vhi - vlo) * (longint'(pos) - alo), ahi - alo);
  endfunction

  function automatic pifc_pkg::out_item_t apply_item(pifc_pkg::in_item_t it);
    pifc_pkg::out_item_t r;
    int pos, req, err, aerr;
    longint acc, ff;
    pos = it.position;
    req = it.request_angle;
    ff = 0;
    r = '0;
    case (it.func)
      pifc_pkg::FUNC_TICK: begin
        if (it.disabled) begin
          if (!stamp_held) begin
            stamp = it.time_ms;
            stamp_held = 1;
          end else if (32'(it.time_ms - stamp) > pifc_pkg::DisableHoldMs) begin
            sp_q = pos;
          end
          isum = 0;
        end else begin
          err = sp_q - pos;
          aerr = (err < 0) ? -err : err;
          stamp_held = 0;
          if (aerr <= pifc_pkg::DeadbandQ12 || aerr > int'(izone)) begin
            isum = 0;
          end else begin
            acc = longint'(isum) + err;
            if (acc > 64'sd2147483647) acc = 64'sd2147483647;
            if (acc < -64'sd2147483648) acc = -64'sd2147483648;
            isum = int'(acc);
          end
        end
        if (slot_en != 0 && pos > win_low && pos < win_high) r.gain_slot = 1'b1;
        ff = table_value(pos) + round_div(longint'(ki) * longint'(isum), 16384);
        if (ff > 8388607) ff = 8388607;
        if (ff < -8388608) ff = -8388608;
      end
      pifc_pkg::FUNC_REQUEST: begin
        if (req > int'(angle_ceiling)) r.status = pifc_pkg::STATUS_TOO_HIGH;
        else if (req < int'(angle_floor)) r.status = pifc_pkg::STATUS_TOO_LOW;
        else if (!running) r.status = pifc_pkg::STATUS_NOT_RUN;
        else sp_q = req;
      end
      pifc_pkg::FUNC_START: begin
        running = 1;
        sp_q = int'(angle_floor);
        isum = 0;
      end
      default: begin
        pt_angle[it.point_index] = it.point_angle;
        pt_volts[it.point_index] = it.point_volts;
      end
    endcase
    r.setpoint = 16'(sp_q);
    r.feedforward = 24'(ff);
    return r;
  endfunction

  always @(posedge clk) begin
    pifc_pkg::out_item_t exp_r, got;
    if (rst) begin
      angle_floor = 0; angle_ceiling = 25723; ki = 0; izone = 0;
      slot_en = 0; win_low = 0; win_high = 0; tbl_count = 0;
      sp_q = 0; isum = 0; running = 0; stamp = '0; stamp_held = 1;
      expected_results.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pifc_pkg::REG_MIN_ANGLE:   angle_floor = cfg_data[14:0];
          pifc_pkg::REG_MAX_ANGLE:   angle_ceiling = cfg_data[14:0];
          pifc_pkg::REG_KI:          ki = cfg_data[14:0];
          pifc_pkg::REG_IZONE:       izone = cfg_data[14:0];
          pifc_pkg::REG_SLOT_EN:     slot_en = cfg_data[0];
          pifc_pkg::REG_WIN_LOW:     win_low = $signed(cfg_data);
          pifc_pkg::REG_WIN_HIGH:    win_high = $signed(cfg_data);
          pifc_pkg::REG_TABLE_COUNT: tbl_count = cfg_data[4:0];
          default: ;
        endcase
      end
      // Compare before queueing so a result never meets its own item.
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result transfer %p", $time, got);
          errors <= errors + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.setpoint !== exp_r.setpoint || got.feedforward !== exp_r.feedforward ||
              got.gain_slot !== exp_r.gain_slot || got.status !== exp_r.status) begin
            $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
            errors <= errors + 1;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) expected_results.push_back(apply_item(in_ch.data));
      pending <= expected_results.size();
    end
  end
endmodule

### verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 50000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [pifc_pkg::CfgIndexWidth-1:0] cfg_index = '0;
  logic [pifc_pkg::CfgDataWidth-1:0] cfg_data = '0;
  int errors, pending;
  bit hold_off, free_run;
  logic [31:0] now_ms;
  int idle_cycles;

  pifc_in_if in_ch();
  pifc_out_if out_ch();

  pivot_integral_feedforward_controller u_top (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pifc_scoreboard u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // Result side: random stalls, with a long hold-off when asked.
  initial begin
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_off) begin
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end else if (free_run || r >= 25) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else if (r < 3) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(20, 300)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send(pifc_pkg::in_item_t it);
    int r;
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = $urandom_range(0, 99);
    if (!free_run && r < 30) begin
      in_ch.valid <= 1'b0;
      if (r < 3) repeat ($urandom_range(40, 400)) @(posedge clk);
      else repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic [pifc_pkg::CfgIndexWidth-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= pifc_pkg::CfgDataWidth'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic pifc_pkg::in_item_t make_tick(int pos, bit dis, logic [31:0] t);
    pifc_pkg::in_item_t it;
    it = '0;
    it.func = pifc_pkg::FUNC_TICK;
    it.position = 16'(pos);
    it.disabled = dis;
    it.time_ms = t;
    return it;
  endfunction

  function automatic pifc_pkg::in_item_t make_req(int a);
    pifc_pkg::in_item_t it;
    it = '0;
    it.func = pifc_pkg::FUNC_REQUEST;
    it.request_angle = 16'(a);
    return it;
  endfunction

  function automatic pifc_pkg::in_item_t make_load(int idx, int a, int v);
    pifc_pkg::in_item_t it;
    it = '0;
    it.func = pifc_pkg::FUNC_LOAD;
    it.point_index = 4'(idx);
    it.point_angle = 16'(a);
    it.point_volts = 16'(v);
    return it;
  endfunction

  function automatic pifc_pkg::in_item_t make_start();
    pifc_pkg::in_item_t it;
    it = '0;
    it.func = pifc_pkg::FUNC_START;
    return it;
  endfunction

  // Well-formed traffic around a working angle, with some raw noise.
  task automatic random_item(int centre);
    pifc_pkg::in_item_t it;
    logic [127:0] raw;
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      now_ms = now_ms + $urandom_range(0, 400);
      if ($urandom_range(0, 40) == 0) now_ms = $urandom;
      it = make_tick(centre + $signed($urandom_range(0, 1200)) - 600,
                     $urandom_range(0, 3) == 0, now_ms);
    end else if (r < 75) begin
      it = make_req($urandom_range(0, 3) == 0 ? $signed(16'($urandom))
                                               : $urandom_range(0, 25723));
    end else if (r < 80) begin
      it = make_start();
    end else if (r < 90) begin
      r = $urandom_range(0, 15);
      it = make_load(r, r * 3000 - 24000 + $urandom_range(0, 2500), $signed(16'($urandom)));
    end else begin
      raw = {$urandom, $urandom, $urandom, $urandom};
      it = raw[$bits(pifc_pkg::in_item_t)-1:0];
    end
    send(it);
  endtask

  initial begin
    int centre, k;
    now_ms = 32'd1000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, block not yet running.
    send(make_tick(16'sh7FFF, 0, now_ms));
    send(make_tick(-32768, 1, now_ms));
    send(make_req(32767));
    send(make_req(-32768));
    send(make_req(100));
    for (k = 0; k < 16; k++) begin
      send(make_load(k, k * 4000 - 30000, (k == 0) ? -32768 : (k == 15) ? 32767 : k * 1111));
    end
    drain();
    write_reg(pifc_pkg::REG_TABLE_COUNT, 16);
    write_reg(pifc_pkg::REG_KI, 20480);
    write_reg(pifc_pkg::REG_IZONE, 25723);
    write_reg(pifc_pkg::REG_SLOT_EN, 1);
    write_reg(pifc_pkg::REG_WIN_LOW, -32768);
    write_reg(pifc_pkg::REG_WIN_HIGH, 32767);
    send(make_start());
    send(make_req(5000));
    send(make_tick(-32768, 0, now_ms));    // below the first key
    send(make_tick(32767, 0, now_ms));     // above the last key
    send(make_tick(5010, 0, now_ms));      // inside the deadband
    send(make_tick(-26000, 0, now_ms));    // exactly on a key
    send(make_tick(-25999, 0, now_ms));
    send(make_load(5, -30000, 77));        // key out of order
    send(make_tick(-9000, 0, now_ms));
    // Disable timer across the wrap of the millisecond count.
    send(make_tick(1234, 1, 32'hFFFF_FF00));
    send(make_tick(1234, 1, 32'h0000_00F4));
    send(make_tick(4321, 1, 32'h0000_00F5));
    send(make_load(5, -10000, 4000));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      write_reg(pifc_pkg::REG_MIN_ANGLE,
                phase == 0 ? 0 : phase == 1 ? 25723 : $urandom_range(0, 8000));
      write_reg(pifc_pkg::REG_MAX_ANGLE,
                phase == 1 ? 0 : phase == 2 ? 25723 : $urandom_range(8000, 25723));
      write_reg(pifc_pkg::REG_KI,
                phase == 0 ? 0 : phase == 3 ? 20480 : $urandom_range(0, 20480));
      write_reg(pifc_pkg::REG_IZONE,
                phase == 0 ? 0 : phase == 4 ? 25723 : $urandom_range(0, 2000));
      write_reg(pifc_pkg::REG_SLOT_EN, phase % 2);
      write_reg(pifc_pkg::REG_WIN_LOW, $signed(16'($urandom_range(0, 65535))));
      write_reg(pifc_pkg::REG_WIN_HIGH,
                phase == 5 ? 32767 : $signed(16'($urandom_range(0, 65535))));
      write_reg(pifc_pkg::REG_TABLE_COUNT,
                phase == 2 ? 0 : phase == 3 ? 1 : $urandom_range(2, 16));
      free_run = (phase == 4);
      if (phase == 2) hold_off = 1;
      send(make_start());
      centre = $urandom_range(0, 25723);
      for (k = 0; k < 115; k++) begin
        if (k == 60 && phase == 3) drain();
        if (k % 20 == 0) centre = $urandom_range(0, 25723);
        random_item(centre);
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
